// ----- hw/rtl/buddy_tree_allocator_defines.svh -----
// Assertion macros for the buddy tree allocator checker.
`ifndef BUDDY_TREE_ALLOCATOR_DEFINES_SVH
`define BUDDY_TREE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BTA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy tree allocator: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy tree allocator: check failed");

`endif

// ----- hw/rtl/btalloc_pkg.sv -----
// Types and codes shared by the buddy tree allocator modules.
package btalloc_pkg;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [8:0] req_size;
        logic [7:0] unit_offset;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] alloc_offset;
        logic [8:0] block_units;
    } out_word_t;

    typedef enum logic [1:0] {
        OP_GE,
        OP_MAX,
        OP_MERGE
    } node_op_t;

endpackage

// ----- hw/rtl/btalloc_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
module btalloc_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 511
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/btalloc_node_unit.sv -----
// Shared node unit: fit compare, max of two children, buddy merge.
module btalloc_node_unit import btalloc_pkg::*; #(
    parameter int W = 10
) (
    input  node_op_t       op,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    input  logic [W-1:0]   full,
    output logic [W-1:0]   y,
    output logic           flag
);

    logic [W:0]   sum;
    logic [W-1:0] mx;

    assign sum = {1'b0, a} + {1'b0, b};
    assign mx  = (a > b) ? a : b;

    always_comb
    begin
        case (op)
            OP_GE:
            begin
                y    = a;
                flag = (a >= b);
            end
            OP_MAX:
            begin
                y    = mx;
                flag = 1'b0;
            end
            OP_MERGE:
            begin
                flag = (sum == {1'b0, full});
                y    = flag ? full : mx;
            end
            default:
            begin
                y    = mx;
                flag = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/buddy_tree_allocator.sv -----
// Top level of the buddy tree allocator: sequencer, tree RAM and node unit.
//
// Usage: drive cmd and raise start; the word is taken at a clock edge with
// start high and busy low. busy stays high while the operation runs. The
// result word appears on rsp for exactly one cycle with done high; the
// receiver cannot stall it, so it must sample rsp whenever done is high.
// Allocate: status ok with alloc_offset and block_units, or no-fit.
// Free and query act on the allocated block that contains unit_offset.
// A bad offset or unused action is answered in the cycle after the word is
// taken, a no-fit once S_ROOT has read the root. Allocate walks down from
// the root in S_DOWN, writes the block in S_MARK and walks back up in S_UP.
// Free walks up from the leaf in S_FIND to the allocated block, then goes
// through S_MARK and S_UP; query only walks up in S_FIND. The single tree
// RAM port pair handles one node per cycle. A new word can be taken in the
// cycle done is high. Reset: the tree RAM is swept to full subtree sizes,
// one node per cycle, with busy high.
module buddy_tree_allocator import btalloc_pkg::*; #(
    parameter int POOL_UNITS = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  cmd,
    output logic      done,
    output out_word_t rsp
);

    localparam int LEVELS = $clog2(POOL_UNITS);
    localparam int IW     = LEVELS + 1;
    localparam int NW     = LEVELS + 1;
    localparam int CW     = (NW > 10) ? NW : 10;
    localparam int NODES  = 2 * POOL_UNITS - 1;

    localparam logic [IW-1:0]       LAST_NODE = IW'(NODES - 1);
    localparam logic [IW-1:0]       LEAF_BASE = IW'(POOL_UNITS - 1);
    localparam logic [NW-1:0]       POOL_N    = NW'(POOL_UNITS);
    localparam logic [CW-1:0]       POOL_C    = CW'(POOL_UNITS);
    localparam logic [LEVELS+7:0]   POOL_OW   = (LEVELS + 8)'(POOL_UNITS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT,
        S_DOWN,
        S_MARK,
        S_UP,
        S_FIND
    } state_t;

    function automatic logic [9:0] round_pow2(input logic [8:0] req);
        logic [9:0] w;
        w = 10'd512;
        for (int k = 9; k >= 0; k--)
        begin
            if ((10'd1 << k) >= {1'b0, req})
            begin
                w = 10'd1 << k;
            end
        end
        return w;
    endfunction

    function automatic logic [IW-1:0] left_of(input logic [IW-1:0] i);
        return {i[IW-2:0], 1'b1};
    endfunction

    function automatic logic [IW-1:0] parent_of(input logic [IW-1:0] i);
        return (i - 1'b1) >> 1;
    endfunction

    function automatic logic [IW-1:0] sib_of(input logic [IW-1:0] i);
        return i[0] ? (i + 1'b1) : (i - 1'b1);
    endfunction

    function automatic out_word_t make_rsp(input logic [1:0] st,
                                           input logic [LEVELS-1:0] off,
                                           input logic [NW-1:0] sz);
        out_word_t        r;
        logic [LEVELS+7:0] ow;
        logic [NW+8:0]    sw;
        ow = (LEVELS + 8)'(off);
        sw = (NW + 9)'(sz);
        r.status       = st;
        r.alloc_offset = ow[7:0];
        r.block_units  = sw[8:0];
        return r;
    endfunction

    state_t            state_reg, state_next;
    logic              done_reg, done_next;
    out_word_t         rsp_reg, rsp_next;
    logic [IW-1:0]     clr_idx_reg, clr_idx_next;
    logic [NW-1:0]     clr_size_reg, clr_size_next;

    logic [IW-1:0]     idx_reg, idx_next;
    logic [NW-1:0]     sz_reg, sz_next;
    logic [NW-1:0]     lvl_sz_reg, lvl_sz_next;
    logic [NW-1:0]     cur_reg, cur_next;
    logic [LEVELS-1:0] off_reg, off_next;
    logic [LEVELS-1:0] ofs_reg, ofs_next;
    logic [CW-1:0]     want_reg, want_next;
    logic              is_free_reg, is_free_next;

    logic              we, re;
    logic [IW-1:0]     waddr, raddr;
    logic [NW-1:0]     wdata, rdata;

    node_op_t          op;
    logic [CW-1:0]     ua, ub, ufull, uy;
    logic              uflag;

    logic [IW-1:0]     clr_inc;
    logic [LEVELS+7:0] ofs_wide;
    logic              ofs_ok;
    logic [LEVELS-1:0] ofs_pool;
    logic [IW-1:0]     leaf;
    logic [CW-1:0]     rdata_ext;
    logic [IW-1:0]     left, new_idx, par;
    logic [NW-1:0]     half, psz, up_val;
    logic [LEVELS-1:0] blk_start;

    btalloc_ram #(
        .WIDTH (NW),
        .DEPTH (NODES)
    ) u_tree (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    btalloc_node_unit #(
        .W (CW)
    ) u_node (
        .op   (op),
        .a    (ua),
        .b    (ub),
        .full (ufull),
        .y    (uy),
        .flag (uflag)
    );

    assign clr_inc   = clr_idx_reg + 1'b1;
    assign ofs_wide  = (LEVELS + 8)'(cmd.unit_offset);
    assign ofs_ok    = (ofs_wide < POOL_OW);
    assign ofs_pool  = ofs_wide[LEVELS-1:0];
    assign leaf      = IW'(ofs_pool) + LEAF_BASE;
    assign rdata_ext = CW'(rdata);
    assign left      = left_of(idx_reg);
    assign new_idx   = uflag ? left : (left + 1'b1);
    assign par       = parent_of(idx_reg);
    assign half      = sz_reg >> 1;
    assign psz       = lvl_sz_reg << 1;
    assign up_val    = NW'(uy);
    assign blk_start = ofs_reg & ~(sz_reg[LEVELS-1:0] - 1'b1);

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        clr_idx_next  = clr_idx_reg;
        clr_size_next = clr_size_reg;
        idx_next      = idx_reg;
        sz_next       = sz_reg;
        lvl_sz_next   = lvl_sz_reg;
        cur_next      = cur_reg;
        off_next      = off_reg;
        ofs_next      = ofs_reg;
        want_next     = want_reg;
        is_free_next  = is_free_reg;
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;
        re            = 1'b0;
        raddr         = '0;
        op            = OP_GE;
        ua            = rdata_ext;
        ub            = want_reg;
        ufull         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                we           = 1'b1;
                waddr        = clr_idx_reg;
                wdata        = clr_size_reg;
                clr_idx_next = clr_inc;
                if (((clr_inc + 1'b1) & clr_inc) == '0)
                begin
                    clr_size_next = clr_size_reg >> 1;
                end
                if (clr_idx_reg == LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ofs_next     = ofs_pool;
                    is_free_next = (cmd.action == ACT_FREE);
                    want_next    = CW'(round_pow2(cmd.req_size));
                    case (cmd.action)
                        ACT_ALLOC:
                        begin
                            re         = 1'b1;
                            raddr      = '0;
                            state_next = S_ROOT;
                        end
                        ACT_FREE, ACT_QUERY:
                        begin
                            if (ofs_ok)
                            begin
                                re         = 1'b1;
                                raddr      = leaf;
                                idx_next   = leaf;
                                sz_next    = NW'(1);
                                state_next = S_FIND;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                rsp_next  = make_rsp(STAT_BAD, '0, '0);
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = make_rsp(STAT_BAD, '0, '0);
                        end
                    endcase
                end
            end
            S_ROOT:
            begin
                if (!uflag)
                begin
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(STAT_NOFIT, '0, '0);
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = '0;
                    sz_next  = POOL_N;
                    off_next = '0;
                    if (POOL_C > want_reg)
                    begin
                        re         = 1'b1;
                        raddr      = left_of('0);
                        state_next = S_DOWN;
                    end
                    else
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_DOWN:
            begin
                idx_next = new_idx;
                sz_next  = half;
                off_next = uflag ? off_reg : (off_reg + LEVELS'(half));
                if (CW'(half) > want_reg)
                begin
                    re    = 1'b1;
                    raddr = left_of(new_idx);
                end
                else
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                we          = 1'b1;
                waddr       = idx_reg;
                wdata       = is_free_reg ? sz_reg : '0;
                cur_next    = wdata;
                lvl_sz_next = sz_reg;
                if (idx_reg == '0)
                begin
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(STAT_OK, off_reg, sz_reg);
                    state_next = S_IDLE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = sib_of(idx_reg);
                    state_next = S_UP;
                end
            end
            S_UP:
            begin
                op          = is_free_reg ? OP_MERGE : OP_MAX;
                ua          = CW'(cur_reg);
                ub          = rdata_ext;
                ufull       = CW'(psz);
                we          = 1'b1;
                waddr       = par;
                wdata       = up_val;
                idx_next    = par;
                cur_next    = up_val;
                lvl_sz_next = psz;
                if (par == '0)
                begin
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(STAT_OK, off_reg, sz_reg);
                    state_next = S_IDLE;
                end
                else
                begin
                    re    = 1'b1;
                    raddr = sib_of(par);
                end
            end
            S_FIND:
            begin
                if (rdata == '0)
                begin
                    off_next = blk_start;
                    if (is_free_reg)
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        rsp_next   = make_rsp(STAT_OK, blk_start, sz_reg);
                        state_next = S_IDLE;
                    end
                end
                else if (idx_reg == '0)
                begin
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(STAT_BAD, '0, '0);
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = par;
                    sz_next  = sz_reg << 1;
                    re       = 1'b1;
                    raddr    = par;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            done_reg     <= 1'b0;
            rsp_reg      <= '0;
            clr_idx_reg  <= '0;
            clr_size_reg <= POOL_N;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            rsp_reg      <= rsp_next;
            clr_idx_reg  <= clr_idx_next;
            clr_size_reg <= clr_size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        sz_reg      <= sz_next;
        lvl_sz_reg  <= lvl_sz_next;
        cur_reg     <= cur_next;
        off_reg     <= off_next;
        ofs_reg     <= ofs_next;
        want_reg    <= want_next;
        is_free_reg <= is_free_next;
    end

endmodule

// ----- hw/rtl/btalloc_checker.sv -----
// Port-level checker for the buddy tree allocator, bound to the top level.
`include "buddy_tree_allocator_defines.svh"

module btalloc_checker import btalloc_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input in_word_t  cmd,
    input logic      done,
    input out_word_t rsp
);

    // a result word always lands with the block ready for the next word
    `BTA_ASSERT_NOW(a_done_idle, done, !busy)

    // an accepted word either answers at once or keeps the block busy
    `BTA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)

    // error answers carry no offset and no size
    `BTA_ASSERT_NOW(a_err_zero, done && (rsp.status != STAT_OK),
                    (rsp.alloc_offset == 8'd0) && (rsp.block_units == 9'd0))

    // a good answer names a power-of-two block
    `BTA_ASSERT_NOW(a_ok_pow2, done && (rsp.status == STAT_OK), $onehot(rsp.block_units))

endmodule

bind buddy_tree_allocator btalloc_checker u_btalloc_checker (.*);

// ----- bench/alloc_checker.sv -----
// Checker for the buddy tree allocator: tracks the free-run tree and compares every result word.
module alloc_checker import btalloc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  in_word_t  cmd,
    input  logic      done,
    input  out_word_t rsp,
    output int        mismatches,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNITS = 256;
    localparam int NODES = 2 * UNITS - 1;

    logic [8:0] free_span [0:NODES-1];
    out_word_t  expected_rsp [$];

    function automatic int unsigned parent_of(input int unsigned node);
        return (node + 1) / 2 - 1;
    endfunction

    // Applies one command word to the tree copy and returns the word the block must answer.
    function automatic out_word_t serve_word(input in_word_t w);
        out_word_t   r;
        logic [9:0]  want;
        logic [9:0]  run;
        logic [9:0]  pair_sum;
        logic [8:0]  lo;
        logic [8:0]  hi;
        int unsigned node;
        r = '0;
        r.status = STAT_BAD;
        case (w.action)
            ACT_ALLOC:
            begin
                want = 10'd1;
                while (want < {1'b0, w.req_size})
                    want = want << 1;
                if ({1'b0, free_span[0]} < want)
                    r.status = STAT_NOFIT;
                else
                begin
                    node = 0;
                    run  = 10'(UNITS);
                    while (run > want)
                    begin
                        node = ({1'b0, free_span[2*node+1]} >= want) ? 2*node + 1 : 2*node + 2;
                        run  = run >> 1;
                    end
                    free_span[node]  = '0;
                    r.status       = STAT_OK;
                    r.alloc_offset = 8'((node + 1) * run - UNITS);
                    r.block_units  = run[8:0];
                    while (node != 0)
                    begin
                        node = parent_of(node);
                        lo   = free_span[2*node+1];
                        hi   = free_span[2*node+2];
                        free_span[node] = (lo > hi) ? lo : hi;
                    end
                end
            end
            ACT_FREE, ACT_QUERY:
            begin
                node = w.unit_offset + UNITS - 1;
                run  = 10'd1;
                while (free_span[node] != 0 && node != 0)
                begin
                    node = parent_of(node);
                    run  = run << 1;
                end
                if (free_span[node] == 0)
                begin
                    r.status       = STAT_OK;
                    r.alloc_offset = 8'((node + 1) * run - UNITS);
                    r.block_units  = run[8:0];
                    if (w.action == ACT_FREE)
                    begin
                        free_span[node] = run[8:0];
                        while (node != 0)
                        begin
                            node     = parent_of(node);
                            run      = run << 1;
                            lo       = free_span[2*node+1];
                            hi       = free_span[2*node+2];
                            pair_sum = {1'b0, lo} + {1'b0, hi};
                            // buddies merge when both halves are wholly free
                            if (pair_sum == run)
                                free_span[node] = run[8:0];
                            else
                                free_span[node] = (lo > hi) ? lo : hi;
                        end
                    end
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic report_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
                free_span[i] = 9'(UNITS >> ($clog2(i + 2) - 1));
            expected_rsp.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, rsp);
                    mismatches++;
                end
                else
                begin
                    out_word_t exp_word;
                    exp_word = expected_rsp.pop_front();
                    report_field("status", int'(exp_word.status), int'(rsp.status));
                    report_field("alloc_offset", int'(exp_word.alloc_offset),
                                 int'(rsp.alloc_offset));
                    report_field("block_units", int'(exp_word.block_units),
                                 int'(rsp.block_units));
                end
            end
            if (start && !busy)
                expected_rsp.push_back(serve_word(cmd));
            outstanding = expected_rsp.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the buddy tree allocator: clock, reset, command stimulus and verdict.
module tb_top;
    import btalloc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 100000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  cmd;
    logic      done;
    out_word_t rsp;
    int        mismatches;
    int        outstanding;
    int        cycles;
    bit        no_idle;

    buddy_tree_allocator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    alloc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic in_word_t make_word(input logic [1:0] act, input logic [8:0] units,
                                           input logic [7:0] offset);
        in_word_t w;
        w.action      = act;
        w.req_size    = units;
        w.unit_offset = offset;
        return w;
    endfunction

    function automatic in_word_t random_word();
        int pick;
        logic [8:0] units;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            units = 9'($urandom_range(0, 8));
        else if (pick < 90)
            units = 9'($urandom_range(9, 64));
        else
            units = 9'($urandom_range(0, 511));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return make_word(ACT_ALLOC, units, 8'($urandom));
        else if (pick < 80)
            return make_word(ACT_FREE, 9'($urandom), 8'($urandom));
        else if (pick < 95)
            return make_word(ACT_QUERY, 9'($urandom), 8'($urandom));
        else
            return make_word(ACT_UNUSED, 9'($urandom), 8'($urandom));
    endfunction

    function automatic int idle_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    // Returns at the edge where the word is taken.
    task automatic send_word(input in_word_t w, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= w;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        wait (outstanding == 0);
    endtask

    initial
    begin
        start   = 1'b0;
        cmd     = '0;
        rst_n   = 1'b0;
        no_idle = 1'b0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty pool: free/query of unallocated units, unused action, oversized allocate
        send_word(make_word(ACT_QUERY, 9'd0, 8'd0), idle_gap());
        send_word(make_word(ACT_FREE, 9'h1FF, 8'd255), idle_gap());
        send_word(make_word(ACT_UNUSED, 9'h1FF, 8'hFF), idle_gap());
        send_word(make_word(ACT_ALLOC, 9'd511, 8'd0), idle_gap());
        // zero size, exact and rounded sizes
        send_word(make_word(ACT_ALLOC, 9'd0, 8'hFF), idle_gap());
        send_word(make_word(ACT_ALLOC, 9'd1, 8'd0), idle_gap());
        send_word(make_word(ACT_ALLOC, 9'd3, 8'd0), idle_gap());
        send_word(make_word(ACT_ALLOC, 9'd256, 8'd0), idle_gap());
        // offset inside a block
        send_word(make_word(ACT_QUERY, 9'd0, 8'd6), idle_gap());
        send_word(make_word(ACT_FREE, 9'd0, 8'd7), idle_gap());
        send_word(make_word(ACT_FREE, 9'd0, 8'd0), idle_gap());
        send_word(make_word(ACT_FREE, 9'd0, 8'd1), idle_gap());
        send_word(make_word(ACT_QUERY, 9'd0, 8'd1), idle_gap());
        // whole pool, then too-large requests
        send_word(make_word(ACT_ALLOC, 9'd256, 8'd0), idle_gap());
        send_word(make_word(ACT_QUERY, 9'd0, 8'd255), idle_gap());
        send_word(make_word(ACT_ALLOC, 9'd1, 8'd0), idle_gap());
        send_word(make_word(ACT_FREE, 9'd0, 8'd128), idle_gap());
        send_word(make_word(ACT_ALLOC, 9'd257, 8'd0), idle_gap());
        send_word(make_word(ACT_ALLOC, 9'd128, 8'd0), idle_gap());
        send_word(make_word(ACT_ALLOC, 9'd65, 8'd0), idle_gap());
        send_word(make_word(ACT_ALLOC, 9'd128, 8'd0), idle_gap());
        send_word(make_word(ACT_QUERY, 9'd0, 8'd200), idle_gap());
        send_word(make_word(ACT_FREE, 9'd0, 8'd127), idle_gap());
        send_word(make_word(ACT_FREE, 9'd0, 8'd192), idle_gap());
        send_word(make_word(ACT_FREE, 9'd0, 8'd255), idle_gap());

        for (int n = 0; n < 500; n++)
        begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if (n == 150 || n == 350)
                drain();
            send_word(random_word(), idle_gap());
        end

        @(negedge clk);
        start <= 1'b0;
        wait (outstanding == 0);
        repeat (40)
            @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
